/* hw/rtl/dslc_pkg.sv */
// Package for the display sleep/lock controller.
// Holds the power modes, request and command codes, register indexes and shared structs.
package dslc_pkg;

	localparam int unsigned TIME_W = 64;
	localparam int unsigned TIMEOUT_W = 32;
	localparam int unsigned KEY_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [TIMEOUT_W-1:0] SLEEP_TIMEOUT_RST = 32'd30000;
	localparam logic [TIMEOUT_W-1:0] LOCK_TIMEOUT_RST = 32'd60000;

	typedef enum logic [1:0] {
		MODE_ACTIVE = 2'd0,
		MODE_SLEEP  = 2'd1,
		MODE_LOCKED = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		OP_KEY    = 2'd0,
		OP_TICK   = 2'd1,
		OP_UNLOCK = 2'd2,
		OP_NOTICE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_SLEEP = 2'd1,
		CMD_WAKE  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLEEP_TIMEOUT = 2'd0,
		REG_SLEEP_ENABLE  = 2'd1,
		REG_LOCK_TIMEOUT  = 2'd2,
		REG_LOCK_ENABLE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] sleep_timeout_ms;
		logic                 sleep_enable;
		logic [TIMEOUT_W-1:0] lock_timeout_ms;
		logic                 lock_enable;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic              lock_screen_revealed;
		logic [TIME_W-1:0] last_activity_time;
		logic [TIME_W-1:0] sleep_start_time;
		logic              entered_sleep_pending;
	} state_t;

	typedef struct packed {
		logic             key_consumed;
		mode_t            power_state;
		cmd_t             display_command;
		logic             show_lock_screen;
		logic             pop_screen;
		logic             redraw_request;
		logic             forward_valid;
		logic [KEY_W-1:0] forwarded_key;
		logic             sleep_notice;
	} result_t;

endpackage

/* hw/rtl/dslc_cfg_regs.sv */
// Configuration register file for the display sleep/lock controller.
// Depends on dslc_pkg for the register indexes, widths and reset values.
module dslc_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dslc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dslc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output dslc_pkg::cfg_t                       cfg
);

	dslc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sleep_timeout_ms <= dslc_pkg::SLEEP_TIMEOUT_RST;
			cfg_q.sleep_enable     <= 1'b1;
			cfg_q.lock_timeout_ms  <= dslc_pkg::LOCK_TIMEOUT_RST;
			cfg_q.lock_enable      <= 1'b1;
		end else if (cfg_we) begin
			case (dslc_pkg::reg_idx_t'(cfg_index))
				dslc_pkg::REG_SLEEP_TIMEOUT: cfg_q.sleep_timeout_ms <= cfg_wdata;
				dslc_pkg::REG_SLEEP_ENABLE:  cfg_q.sleep_enable     <= cfg_wdata[0];
				dslc_pkg::REG_LOCK_TIMEOUT:  cfg_q.lock_timeout_ms  <= cfg_wdata;
				dslc_pkg::REG_LOCK_ENABLE:   cfg_q.lock_enable      <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/dslc_event_logic.sv */
// Next-state and result logic for one request of the display sleep/lock controller.
// Purely combinational; depends on dslc_pkg for the state, config and result structs.
module dslc_event_logic (
	input  dslc_pkg::cfg_t                   cfg,
	input  dslc_pkg::state_t                 cur,
	input  dslc_pkg::op_t                    op,
	input  logic [dslc_pkg::TIME_W-1:0]      now_ms,
	input  logic [dslc_pkg::KEY_W-1:0]       key_code,
	output dslc_pkg::state_t                 nxt,
	output dslc_pkg::result_t                res
);

	logic [dslc_pkg::TIME_W-1:0] idle_ms;
	logic [dslc_pkg::TIME_W-1:0] asleep_ms;
	logic                        sleep_due;
	logic                        lock_due;

	// Elapsed times wrap modulo 2^64; the 32-bit timeout is compared zero-extended.
	assign idle_ms   = now_ms - cur.last_activity_time;
	assign asleep_ms = now_ms - cur.sleep_start_time;
	assign sleep_due = cfg.sleep_enable &&
		((|idle_ms[dslc_pkg::TIME_W-1:dslc_pkg::TIMEOUT_W]) ||
		 (idle_ms[dslc_pkg::TIMEOUT_W-1:0] >= cfg.sleep_timeout_ms));
	assign lock_due = cfg.lock_enable &&
		((|asleep_ms[dslc_pkg::TIME_W-1:dslc_pkg::TIMEOUT_W]) ||
		 (asleep_ms[dslc_pkg::TIMEOUT_W-1:0] >= cfg.lock_timeout_ms));

	always_comb begin
		nxt = cur;
		res = '0;
		res.display_command = dslc_pkg::CMD_NONE;
		case (op)
			dslc_pkg::OP_KEY: begin
				case (cur.mode)
					dslc_pkg::MODE_ACTIVE: begin
						nxt.last_activity_time = now_ms;
					end
					dslc_pkg::MODE_SLEEP: begin
						nxt.mode = dslc_pkg::MODE_ACTIVE;
						nxt.last_activity_time = now_ms;
						res.display_command = dslc_pkg::CMD_WAKE;
						res.redraw_request = 1'b1;
						res.key_consumed = 1'b1;
					end
					default: begin
						// Locked: the first key reveals the lock screen, later keys go to it.
						res.key_consumed = 1'b1;
						if (!cur.lock_screen_revealed) begin
							res.display_command = dslc_pkg::CMD_WAKE;
							res.show_lock_screen = 1'b1;
							res.redraw_request = 1'b1;
							nxt.lock_screen_revealed = 1'b1;
						end else begin
							res.forward_valid = 1'b1;
							res.forwarded_key = key_code;
						end
					end
				endcase
			end
			dslc_pkg::OP_TICK: begin
				if (cur.mode == dslc_pkg::MODE_ACTIVE) begin
					if (sleep_due) begin
						nxt.mode = dslc_pkg::MODE_SLEEP;
						nxt.sleep_start_time = now_ms;
						nxt.entered_sleep_pending = 1'b1;
						res.display_command = dslc_pkg::CMD_SLEEP;
					end
				end else if (cur.mode == dslc_pkg::MODE_SLEEP) begin
					if (lock_due) begin
						nxt.mode = dslc_pkg::MODE_LOCKED;
						nxt.lock_screen_revealed = 1'b0;
					end
				end
			end
			dslc_pkg::OP_UNLOCK: begin
				nxt.mode = dslc_pkg::MODE_ACTIVE;
				nxt.lock_screen_revealed = 1'b0;
				nxt.last_activity_time = now_ms;
				res.pop_screen = 1'b1;
				res.redraw_request = 1'b1;
			end
			default: begin
				res.sleep_notice = cur.entered_sleep_pending;
				nxt.entered_sleep_pending = 1'b0;
			end
		endcase
		res.power_state = nxt.mode;
	end

endmodule

/* hw/rtl/display_sleep_lock_controller_core.sv */
// Display sleep/lock controller: top level with request register, state and result register.
// An accepted request waits in the request register and is written to the result register when it advances.
// Throughput: one request per cycle; input stalls only while a full result waits on res_ready.
// Reset (arst_n low) returns to active with reset timeouts and both timeouts enabled.
// Depends on dslc_pkg, dslc_cfg_regs and dslc_event_logic.
module display_sleep_lock_controller_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [dslc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dslc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// Request channel.
	input  logic                              evt_valid,
	output logic                              evt_ready,
	input  logic [1:0]                        op,
	input  logic [dslc_pkg::TIME_W-1:0]       now_ms,
	input  logic [dslc_pkg::KEY_W-1:0]        key_code,
	// Result channel.
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic                              key_consumed,
	output logic [1:0]                        power_state,
	output logic [1:0]                        display_command,
	output logic                              show_lock_screen,
	output logic                              pop_screen,
	output logic                              redraw_request,
	output logic                              forward_valid,
	output logic [dslc_pkg::KEY_W-1:0]        forwarded_key,
	output logic                              sleep_notice
);

	// The controller is a short pipeline: a request register (_s1) holds the incoming
	// request, the event logic evaluates it against the current power state, and at
	// the edge where it advances the state registers and the result register are
	// written together. The next request therefore always sees the state left by the
	// previous one, so requests can follow each other every cycle unless a full result waits.

	dslc_pkg::cfg_t    cfg;
	dslc_pkg::state_t  state_q;
	dslc_pkg::state_t  state_nxt;
	dslc_pkg::result_t res_nxt;
	dslc_pkg::result_t res_q;

	logic                        s1_valid;
	dslc_pkg::op_t               s1_op;
	logic [dslc_pkg::TIME_W-1:0] s1_now;
	logic [dslc_pkg::KEY_W-1:0]  s1_key;
	logic                        s1_adv;
	logic                        res_valid_q;

	dslc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dslc_event_logic u_event_logic (
		.cfg      (cfg),
		.cur      (state_q),
		.op       (s1_op),
		.now_ms   (s1_now),
		.key_code (s1_key),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	// The request in the first stage moves on whenever the result register is empty
	// or its content is being taken in this same cycle.
	assign s1_adv    = s1_valid && (!res_valid_q || res_ready);
	assign evt_ready = !s1_valid || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (evt_ready) begin
			s1_valid <= evt_valid;
		end
	end

	// Payload of the request register needs no reset.
	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid) begin
			s1_op  <= dslc_pkg::op_t'(op);
			s1_now <= now_ms;
			s1_key <= key_code;
		end
	end

	// Power state: control bits and timestamps all reset, matching the power-on state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode                  <= dslc_pkg::MODE_ACTIVE;
			state_q.lock_screen_revealed  <= 1'b0;
			state_q.last_activity_time    <= '0;
			state_q.sleep_start_time      <= '0;
			state_q.entered_sleep_pending <= 1'b0;
		end else if (s1_adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid        = res_valid_q;
	assign key_consumed     = res_q.key_consumed;
	assign power_state      = res_q.power_state;
	assign display_command  = res_q.display_command;
	assign show_lock_screen = res_q.show_lock_screen;
	assign pop_screen       = res_q.pop_screen;
	assign redraw_request   = res_q.redraw_request;
	assign forward_valid    = res_q.forward_valid;
	assign forwarded_key    = res_q.forwarded_key;
	assign sleep_notice     = res_q.sleep_notice;

	// A held request in the first stage must not be overwritten while it waits.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_adv |=> s1_valid && $stable(s1_now) && $stable(s1_key))
		else $error("request register changed while stalled");

	// Keys are only forwarded while the lock screen is up.
	a_fwd_locked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.forward_valid |->
		res_q.power_state == dslc_pkg::MODE_LOCKED)
		else $error("key forwarded outside the locked state");

	// Entering sleep always leaves the notice pending.
	a_sleep_notice: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && res_nxt.display_command == dslc_pkg::CMD_SLEEP |=>
		state_q.entered_sleep_pending && state_q.mode == dslc_pkg::MODE_SLEEP)
		else $error("sleep entered without pending notice");

	// An unlock always ends in the active state with a redraw.
	a_unlock_active: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.pop_screen |->
		res_q.power_state == dslc_pkg::MODE_ACTIVE && res_q.redraw_request)
		else $error("unlock did not return to active");

endmodule

/* tb/display_sleep_lock_controller_core_test.sv */
// Self-checking testbench for display_sleep_lock_controller_core.
// Drives key, tick, unlock and notice requests against a cycle-free model of the power modes.
// Depends on dslc_pkg and the controller RTL only.
module display_sleep_lock_controller_core_test;
	import dslc_pkg::*;

	// Watchdog limit, with ample margin over the slowest legal run.
	localparam int unsigned CYCLE_LIMIT = 800000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  evt_valid;
	logic                  evt_ready;
	logic [1:0]            op;
	logic [TIME_W-1:0]     now_ms;
	logic [KEY_W-1:0]      key_code;
	logic                  res_valid;
	logic                  res_ready;
	logic                  key_consumed;
	logic [1:0]            power_state;
	logic [1:0]            display_command;
	logic                  show_lock_screen;
	logic                  pop_screen;
	logic                  redraw_request;
	logic                  forward_valid;
	logic [KEY_W-1:0]      forwarded_key;
	logic                  sleep_notice;

	display_sleep_lock_controller_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.evt_valid        (evt_valid),
		.evt_ready        (evt_ready),
		.op               (op),
		.now_ms           (now_ms),
		.key_code         (key_code),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.key_consumed     (key_consumed),
		.power_state      (power_state),
		.display_command  (display_command),
		.show_lock_screen (show_lock_screen),
		.pop_screen       (pop_screen),
		.redraw_request   (redraw_request),
		.forward_valid    (forward_valid),
		.forwarded_key    (forwarded_key),
		.sleep_notice     (sleep_notice)
	);

	// Results predicted at request acceptance, oldest first.
	result_t power_results_due[$];

	// Shadow copy of the controller state, advanced once per accepted request.
	mode_t             pm_mode = MODE_ACTIVE;
	logic              pm_revealed = 1'b0;
	logic [TIME_W-1:0] pm_last_activity = '0;
	logic [TIME_W-1:0] pm_sleep_start = '0;
	logic              pm_sleep_pending = 1'b0;

	// Shadow copy of the configuration registers, starting from their reset values.
	logic [TIMEOUT_W-1:0] cf_sleep_timeout = SLEEP_TIMEOUT_RST;
	logic                 cf_sleep_enable = 1'b1;
	logic [TIMEOUT_W-1:0] cf_lock_timeout = LOCK_TIMEOUT_RST;
	logic                 cf_lock_enable = 1'b1;

	// Time cursor for the random requests; it wraps freely at 2^64.
	logic [TIME_W-1:0] stim_clock = '0;

	// Set by a test to make the result sink hold off; the value sets the length of the hold.
	int unsigned rx_hold_request = 0;

	int unsigned cycle_count = 0;
	int unsigned requests_sent = 0;
	int unsigned directed_requests = 0;
	int unsigned results_checked = 0;
	int unsigned mismatch_count = 0;
	int unsigned settings_used = 0;
	int unsigned sleeps_predicted = 0;
	int unsigned locks_predicted = 0;
	int unsigned wakes_predicted = 0;
	int unsigned forwards_predicted = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idle length for either side: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	// Advances the shadow state by one request and returns the result the block must give.
	// All elapsed times are plain 64-bit differences, so they wrap the same way the
	// millisecond counter does.
	function automatic result_t predict_power_event(op_t kind, logic [TIME_W-1:0] stamp,
			logic [KEY_W-1:0] key);
		result_t           r;
		logic [TIME_W-1:0] elapsed;
		r = '0;
		case (kind)
			OP_KEY: begin
				if (pm_mode == MODE_ACTIVE) begin
					// A key while active only restarts the idle timer.
					pm_last_activity = stamp;
				end else if (pm_mode == MODE_SLEEP) begin
					pm_mode = MODE_ACTIVE;
					pm_last_activity = stamp;
					r.display_command = CMD_WAKE;
					r.redraw_request = 1'b1;
					r.key_consumed = 1'b1;
					wakes_predicted++;
				end else if (!pm_revealed) begin
					// First key while locked wakes the panel and brings up the lock screen.
					pm_revealed = 1'b1;
					r.display_command = CMD_WAKE;
					r.show_lock_screen = 1'b1;
					r.redraw_request = 1'b1;
					r.key_consumed = 1'b1;
					wakes_predicted++;
				end else begin
					r.forward_valid = 1'b1;
					r.forwarded_key = key;
					r.key_consumed = 1'b1;
					forwards_predicted++;
				end
			end
			OP_TICK: begin
				if (pm_mode == MODE_ACTIVE) begin
					elapsed = stamp - pm_last_activity;
					if (cf_sleep_enable && elapsed >= {32'd0, cf_sleep_timeout}) begin
						pm_mode = MODE_SLEEP;
						pm_sleep_start = stamp;
						pm_sleep_pending = 1'b1;
						r.display_command = CMD_SLEEP;
						sleeps_predicted++;
					end
				end else if (pm_mode == MODE_SLEEP) begin
					elapsed = stamp - pm_sleep_start;
					if (cf_lock_enable && elapsed >= {32'd0, cf_lock_timeout}) begin
						pm_mode = MODE_LOCKED;
						pm_revealed = 1'b0;
						locks_predicted++;
					end
				end
				// A tick while locked leaves everything as it is.
			end
			OP_UNLOCK: begin
				// Unlock always pops and redraws, even when the display is already active.
				pm_mode = MODE_ACTIVE;
				pm_revealed = 1'b0;
				pm_last_activity = stamp;
				r.pop_screen = 1'b1;
				r.redraw_request = 1'b1;
			end
			default: begin
				r.sleep_notice = pm_sleep_pending;
				pm_sleep_pending = 1'b0;
			end
		endcase
		r.power_state = pm_mode;
		return r;
	endfunction

	// Compares one accepted result with the oldest prediction, field by field.
	function automatic void check_result();
		result_t got;
		result_t want;
		string   bad;
		got.key_consumed = key_consumed;
		got.power_state = mode_t'(power_state);
		got.display_command = cmd_t'(display_command);
		got.show_lock_screen = show_lock_screen;
		got.pop_screen = pop_screen;
		got.redraw_request = redraw_request;
		got.forward_valid = forward_valid;
		got.forwarded_key = forwarded_key;
		got.sleep_notice = sleep_notice;
		results_checked++;
		if (power_results_due.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result %0d arrived with no request outstanding: %h",
					results_checked, got);
			return;
		end
		want = power_results_due.pop_front();
		bad = "";
		if (got.key_consumed !== want.key_consumed) bad = {bad, " key_consumed"};
		if (got.power_state !== want.power_state) bad = {bad, " power_state"};
		if (got.display_command !== want.display_command) bad = {bad, " display_command"};
		if (got.show_lock_screen !== want.show_lock_screen) bad = {bad, " show_lock_screen"};
		if (got.pop_screen !== want.pop_screen) bad = {bad, " pop_screen"};
		if (got.redraw_request !== want.redraw_request) bad = {bad, " redraw_request"};
		if (got.forward_valid !== want.forward_valid) bad = {bad, " forward_valid"};
		if (got.forwarded_key !== want.forwarded_key) bad = {bad, " forwarded_key"};
		if (got.sleep_notice !== want.sleep_notice) bad = {bad, " sleep_notice"};
		if (bad != "") begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result %0d differs in%s: expected %h, got %h",
					results_checked, bad, want, got);
		end
	endfunction

	// Offers one request after an optional idle gap and returns at the edge that accepts it.
	// Valid stays high on return, so a back-to-back request only changes the payload.
	task automatic send_request(input op_t kind, input logic [TIME_W-1:0] stamp,
			input logic [KEY_W-1:0] key, input int unsigned gap);
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid <= 1'b1;
		op <= kind;
		now_ms <= stamp;
		key_code <= key;
		do begin
			@(posedge clk);
		end while (evt_ready !== 1'b1);
		power_results_due.push_back(predict_power_event(kind, stamp, key));
		requests_sent++;
	endtask

	// Stops offering requests and waits until every predicted result has come back,
	// then idles on so the pipeline is truly empty.
	task automatic drain_results();
		evt_valid <= 1'b0;
		while (power_results_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SLEEP_TIMEOUT: cf_sleep_timeout = data;
			REG_SLEEP_ENABLE:  cf_sleep_enable = data[0];
			REG_LOCK_TIMEOUT:  cf_lock_timeout = data;
			default:           cf_lock_enable = data[0];
		endcase
	endtask

	// Writes all four registers with the block idle. The enable writes carry random upper
	// bits, which the block must ignore.
	task automatic set_timeouts(input logic [TIMEOUT_W-1:0] sleep_ms, input logic sleep_on,
			input logic [TIMEOUT_W-1:0] lock_ms, input logic lock_on);
		drain_results();
		write_reg(REG_SLEEP_TIMEOUT, sleep_ms);
		write_reg(REG_SLEEP_ENABLE, {31'($urandom), sleep_on});
		write_reg(REG_LOCK_TIMEOUT, lock_ms);
		write_reg(REG_LOCK_ENABLE, {31'($urandom), lock_on});
		settings_used++;
	endtask

	// Moves the time cursor on. Most steps are small or land right around one of the
	// timeouts, so the idle and sleep comparisons are hit at their boundaries; the rest
	// are large jumps that exercise all 64 bits and the wrap.
	function automatic logic [TIME_W-1:0] next_stamp();
		int unsigned       roll;
		logic [TIME_W-1:0] step;
		roll = $urandom_range(0, 99);
		if (roll < 12)
			step = '0;
		else if (roll < 45)
			step = 64'($urandom_range(0, (cf_sleep_timeout >> 2) + 3));
		else if (roll < 65)
			step = 64'(cf_sleep_timeout) - 64'd1 + 64'($urandom_range(0, 2));
		else if (roll < 85)
			step = 64'(cf_lock_timeout) - 64'd1 + 64'($urandom_range(0, 2));
		else if (roll < 96)
			step = 64'($urandom);
		else
			step = {$urandom, $urandom};
		stim_clock = stim_clock + step;
		return stim_clock;
	endfunction

	// Random requests weighted toward ticks and keys, which are what walk the block through
	// active, sleep and locked. Every so often a burst goes out with no gaps at all.
	task automatic run_random_events(input int unsigned count, input logic no_gaps);
		int unsigned roll;
		int unsigned gap;
		op_t         kind;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 45)
				kind = OP_TICK;
			else if (roll < 75)
				kind = OP_KEY;
			else if (roll < 87)
				kind = OP_UNLOCK;
			else
				kind = OP_NOTICE;
			if (no_gaps || (n % 120) >= 95)
				gap = 0;
			else
				gap = pick_gap();
			send_request(kind, next_stamp(), 8'($urandom), gap);
		end
	endtask

	task automatic random_phase(input logic [TIMEOUT_W-1:0] sleep_ms, input logic sleep_on,
			input logic [TIMEOUT_W-1:0] lock_ms, input logic lock_on, input int unsigned count);
		set_timeouts(sleep_ms, sleep_on, lock_ms, lock_on);
		stim_clock = {$urandom, $urandom};
		run_random_events(count, 1'b0);
	endtask

	// Walks the whole mode cycle with the reset timeouts: the idle boundary one below and
	// exactly at the timeout, the notice read before and after it is set, the lock boundary,
	// a tick while locked, the reveal and forwarding of keys, unlock from locked and from
	// active, and an idle span that crosses the 64-bit wrap.
	task automatic test_reset_defaults();
		send_request(OP_TICK, 64'd0, 8'h00, pick_gap());
		send_request(OP_TICK, 64'd29999, 8'h11, pick_gap());
		send_request(OP_NOTICE, 64'd29999, 8'h22, pick_gap());
		send_request(OP_TICK, 64'd30000, 8'h33, pick_gap());
		send_request(OP_TICK, 64'd89999, 8'h44, pick_gap());
		send_request(OP_NOTICE, 64'd89999, 8'h55, pick_gap());
		send_request(OP_NOTICE, 64'd89999, 8'h66, pick_gap());
		send_request(OP_TICK, 64'd90000, 8'h77, pick_gap());
		send_request(OP_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 8'h88, pick_gap());
		send_request(OP_KEY, 64'd90001, 8'h00, pick_gap());
		send_request(OP_KEY, 64'd90002, 8'hFF, pick_gap());
		send_request(OP_KEY, 64'd90003, 8'h00, pick_gap());
		send_request(OP_UNLOCK, 64'hFFFF_FFFF_FFFF_FFF0, 8'h99, pick_gap());
		send_request(OP_UNLOCK, 64'hFFFF_FFFF_FFFF_FFF0, 8'hAA, pick_gap());
		send_request(OP_KEY, 64'hFFFF_FFFF_FFFF_FFF8, 8'hA5, pick_gap());
		// 0x7528 is exactly 30000 ms after the last key once the counter wraps.
		send_request(OP_TICK, 64'h0000_0000_0000_7528, 8'hBB, pick_gap());
		send_request(OP_KEY, 64'h0000_0000_0000_7529, 8'h3C, pick_gap());
		directed_requests += 17;
	endtask

	// Zero timeouts must transition on the first tick, disabled timeouts never, and the
	// largest timeout only at its exact boundary.
	task automatic test_timeout_extremes();
		set_timeouts(32'd0, 1'b1, 32'd0, 1'b1);
		send_request(OP_TICK, 64'd12345, 8'h01, pick_gap());
		send_request(OP_TICK, 64'd12345, 8'h02, pick_gap());
		send_request(OP_UNLOCK, 64'd12345, 8'h03, pick_gap());
		set_timeouts(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
		send_request(OP_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 8'h04, pick_gap());
		set_timeouts(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
		send_request(OP_TICK, 64'd12345 + 64'hFFFF_FFFE, 8'h05, pick_gap());
		send_request(OP_TICK, 64'd12345 + 64'hFFFF_FFFF, 8'h06, pick_gap());
		send_request(OP_TICK, 64'h0000_0100_0000_0000, 8'h07, pick_gap());
		send_request(OP_NOTICE, 64'd0, 8'h08, pick_gap());
		directed_requests += 8;
	endtask

	// Random traffic under a spread of settings, including both extremes of each timeout
	// and each enable off on its own.
	task automatic test_random_settings();
		random_phase(32'd500, 1'b1, 32'd800, 1'b1, 260);
		random_phase(32'd0, 1'b1, 32'd0, 1'b1, 120);
		random_phase(32'd40, 1'b0, 32'd90, 1'b1, 90);
		random_phase(32'd37, 1'b1, 32'd0, 1'b0, 130);
		random_phase(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 130);
		repeat (4) begin
			random_phase($urandom_range(0, 3000), $urandom_range(0, 9) != 0,
				$urandom_range(0, 3000), $urandom_range(0, 9) != 0, 90);
		end
	endtask

	// The sink holds off for a long stretch while requests keep coming back to back, so
	// the result register fills and the request channel must stall. Afterwards the sender
	// pauses until every outstanding result is back before carrying on.
	task automatic test_backpressure();
		set_timeouts(32'd200, 1'b1, 32'd300, 1'b1);
		stim_clock = {$urandom, $urandom};
		rx_hold_request = 150;
		run_random_events(100, 1'b1);
		drain_results();
		run_random_events(100, 1'b0);
	endtask

	// Result sink: res_ready follows its own rhythm of random stalls, with occasional
	// stretches where it is always ready, and honors hold-off requests from the tests.
	initial begin : result_sink
		int unsigned stall_left;
		int unsigned eager_left;
		stall_left = 0;
		eager_left = 0;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_request != 0) begin
				stall_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (stall_left != 0) begin
				res_ready <= 1'b0;
				stall_left--;
			end else begin
				res_ready <= 1'b1;
				if (eager_left != 0)
					eager_left--;
				else if ($urandom_range(0, 99) < 3)
					eager_left = $urandom_range(20, 60);
				else if ($urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	// Values are sampled at the edge itself, before any register in the block or any
	// testbench drive updates, so the handshake seen here is the one the block saw.
	initial begin : result_monitor
		forever begin
			@(posedge clk);
			if (res_valid === 1'b1 && res_ready === 1'b1)
				check_result();
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timed out after %0d cycles with %0d results outstanding",
			cycle_count, power_results_due.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		// Every input is known from time zero; reset is held low before the tests start.
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SLEEP_TIMEOUT;
		cfg_wdata <= '0;
		evt_valid <= 1'b0;
		op <= OP_KEY;
		now_ms <= '0;
		key_code <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_timeout_extremes();
		test_random_settings();
		test_backpressure();

		drain_results();
		repeat (10) @(posedge clk);
		$display("Ran %0d requests (%0d directed) under %0d register settings; %0d results checked.",
			requests_sent, directed_requests, settings_used, results_checked);
		$display("Modes walked: %0d sleeps, %0d locks, %0d wakes, %0d forwarded keys; %0d mismatches.",
			sleeps_predicted, locks_predicted, wakes_predicted, forwards_predicted, mismatch_count);
		if (mismatch_count == 0 && power_results_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
